@@ hdl/dns_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_pkg
// Shared types and constants of the directional nearest select block.
// ----------------------------------------------------------------------------
package dns_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam int COORD_W = 18;
   localparam int DIFF_W  = 19;
   localparam int MAG_W   = 17;
   localparam int SCORE_W = 20;
   localparam int INDEX_W = 8;

   localparam logic [SCORE_W-1:0] SCORE_ALL_ONES = '1;
   localparam logic [COORD_W-1:0] CORNER_NEAR    = '1;
   localparam logic [COORD_W-1:0] CORNER_FAR     = 18'h07FFF;

   localparam logic [1:0] DIR_ZERO = 2'b00;
   localparam logic [1:0] DIR_POS  = 2'b01;
   localparam logic [1:0] DIR_NEG  = 2'b11;

   localparam logic OP_START = 1'b0;
   localparam logic OP_CAND  = 1'b1;

   typedef struct packed {
      logic               is_start;
      logic [1:0]         dir_x;
      logic [1:0]         dir_y;
      logic               has_current;
      logic               empty_list;
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
      logic [INDEX_W-1:0] index;
      logic               eligible;
      logic               last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ hdl/dns_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_front
// Accepts items, computes the centre or corner point and pre-filters
// candidates before they enter the queue.
// ----------------------------------------------------------------------------
module dns_front #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_op,
   input  logic [1:0]                req_dir_x,
   input  logic [1:0]                req_dir_y,
   input  logic                      req_has_current,
   input  logic                      req_empty_list,
   input  logic [15:0]               req_rect_x,
   input  logic [15:0]               req_rect_y,
   input  logic [15:0]               req_rect_w,
   input  logic [15:0]               req_rect_h,
   input  logic [7:0]                req_entry_index,
   input  logic                      req_focusable,
   input  logic                      req_last,
   input  dns_pkg::queue_status_type q_status,
   output logic                      push,
   output dns_pkg::entry_type        entry
);

   localparam logic [8:0] MAX_LIMIT = 9'(MAX_ENTRIES);

   logic [dns_pkg::COORD_W-1:0] cen_x;
   logic [dns_pkg::COORD_W-1:0] cen_y;
   logic [dns_pkg::COORD_W-1:0] corner_x;
   logic [dns_pkg::COORD_W-1:0] corner_y;
   logic                        use_centre;

   assign cen_x = {{2{req_rect_x[15]}}, req_rect_x} + {3'b000, req_rect_w[15:1]};
   assign cen_y = {{2{req_rect_y[15]}}, req_rect_y} + {3'b000, req_rect_h[15:1]};

   // A negative direction starts from the far corner, anything else from -1.
   assign corner_x = req_dir_x[1] ? dns_pkg::CORNER_FAR : dns_pkg::CORNER_NEAR;
   assign corner_y = req_dir_y[1] ? dns_pkg::CORNER_FAR : dns_pkg::CORNER_NEAR;

   assign use_centre = (req_op == dns_pkg::OP_CAND) || req_has_current;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      entry.is_start    = (req_op == dns_pkg::OP_START);
      entry.dir_x       = req_dir_x;
      entry.dir_y       = req_dir_y;
      entry.has_current = req_has_current;
      entry.empty_list  = req_empty_list;
      entry.point_x     = use_centre ? cen_x : corner_x;
      entry.point_y     = use_centre ? cen_y : corner_y;
      entry.index       = req_entry_index;
      entry.eligible    = req_focusable && ({1'b0, req_entry_index} < MAX_LIMIT);
      entry.last        = req_last;
   end

endmodule

@@ hdl/dns_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_queue
// Short first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
module dns_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  dns_pkg::entry_type        entry,
   input  logic                      pop,
   output dns_pkg::entry_type        head,
   output dns_pkg::queue_status_type status
);

   dns_pkg::entry_type                mem [dns_pkg::QUEUE_DEPTH];
   logic [dns_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [dns_pkg::QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [dns_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [dns_pkg::QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [dns_pkg::QUEUE_CNT_W-1:0]   count_ff;
   logic [dns_pkg::QUEUE_CNT_W-1:0]   count_in;

   assign status.full  = (count_ff == dns_pkg::QUEUE_CNT_W'(dns_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dns_pkg::QUEUE_CNT_W'(dns_pkg::QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into a full queue");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from an empty queue");

endmodule

@@ hdl/dns_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_back
// Holds the query, filters and measures each candidate in one stage, then
// scores it against the running best and issues the answer.
// ----------------------------------------------------------------------------
module dns_back (
   input  logic                      clock,
   input  logic                      reset,
   input  dns_pkg::queue_status_type q_status,
   input  dns_pkg::entry_type        head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_found,
   output logic [7:0]                rsp_best_index
);

   logic                          en;
   logic                          take;

   logic [1:0]                    dir_h_ff, dir_h_in;
   logic [1:0]                    dir_v_ff, dir_v_in;
   logic [dns_pkg::COORD_W-1:0]   origin_x_ff, origin_x_in;
   logic [dns_pkg::COORD_W-1:0]   origin_y_ff, origin_y_in;
   logic                          have_origin_ff, have_origin_in;
   logic [dns_pkg::INDEX_W-1:0]   origin_index_ff, origin_index_in;

   logic [dns_pkg::DIFF_W-1:0]    diff_x, diff_y, neg_x, neg_y;
   logic [dns_pkg::MAG_W-1:0]     mag_x, mag_y;
   logic                          keep;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_is_start_ff;
   logic                          s1_empty_list_ff;
   logic                          s1_last_ff;
   logic                          s1_keep_ff;
   logic [dns_pkg::MAG_W-1:0]     s1_primary_ff;
   logic [dns_pkg::MAG_W-1:0]     s1_cross_ff;
   logic [dns_pkg::INDEX_W-1:0]   s1_index_ff;

   logic                          fire;
   logic [dns_pkg::SCORE_W-1:0]   score;
   logic                          better;
   logic                          next_valid;
   logic [dns_pkg::INDEX_W-1:0]   next_index;

   logic [dns_pkg::SCORE_W-1:0]   lowest_ff, lowest_in;
   logic [dns_pkg::INDEX_W-1:0]   winner_index_ff, winner_index_in;
   logic                          winner_valid_ff, winner_valid_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [dns_pkg::INDEX_W-1:0]   rsp_index_ff, rsp_index_in;

   assign en   = !rsp_valid_ff || !rsp_stall;
   assign take = en && !q_status.empty;
   assign pop  = take;

   // Filter stage: offsets from the origin, their magnitudes and the drop rules.
   assign diff_x = {head.point_x[dns_pkg::COORD_W-1], head.point_x}
                 - {origin_x_ff[dns_pkg::COORD_W-1], origin_x_ff};
   assign diff_y = {head.point_y[dns_pkg::COORD_W-1], head.point_y}
                 - {origin_y_ff[dns_pkg::COORD_W-1], origin_y_ff};
   assign neg_x  = {origin_x_ff[dns_pkg::COORD_W-1], origin_x_ff}
                 - {head.point_x[dns_pkg::COORD_W-1], head.point_x};
   assign neg_y  = {origin_y_ff[dns_pkg::COORD_W-1], origin_y_ff}
                 - {head.point_y[dns_pkg::COORD_W-1], head.point_y};
   assign mag_x  = diff_x[dns_pkg::DIFF_W-1] ? neg_x[dns_pkg::MAG_W-1:0]
                                             : diff_x[dns_pkg::MAG_W-1:0];
   assign mag_y  = diff_y[dns_pkg::DIFF_W-1] ? neg_y[dns_pkg::MAG_W-1:0]
                                             : diff_y[dns_pkg::MAG_W-1:0];

   always_comb begin
      keep = head.eligible;
      if (dir_h_ff == dns_pkg::DIR_ZERO && dir_v_ff == dns_pkg::DIR_ZERO) begin
         keep = 1'b0;
      end
      if (have_origin_ff && head.index == origin_index_ff) begin
         keep = 1'b0;
      end
      if (dir_h_ff == dns_pkg::DIR_POS && (diff_x[dns_pkg::DIFF_W-1] || diff_x == '0)) begin
         keep = 1'b0;
      end
      if (dir_h_ff == dns_pkg::DIR_NEG && !diff_x[dns_pkg::DIFF_W-1]) begin
         keep = 1'b0;
      end
      if (dir_v_ff == dns_pkg::DIR_POS && (diff_y[dns_pkg::DIFF_W-1] || diff_y == '0)) begin
         keep = 1'b0;
      end
      if (dir_v_ff == dns_pkg::DIR_NEG && !diff_y[dns_pkg::DIFF_W-1]) begin
         keep = 1'b0;
      end
   end

   always_comb begin
      dir_h_in        = dir_h_ff;
      dir_v_in        = dir_v_ff;
      origin_x_in     = origin_x_ff;
      origin_y_in     = origin_y_ff;
      have_origin_in  = have_origin_ff;
      origin_index_in = origin_index_ff;
      if (take && head.is_start) begin
         dir_h_in        = head.dir_x;
         dir_v_in        = head.dir_y;
         origin_x_in     = head.point_x;
         origin_y_in     = head.point_y;
         have_origin_in  = head.has_current;
         origin_index_in = head.index;
      end
      s1_valid_in = en ? !q_status.empty : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_h_ff       <= dns_pkg::DIR_ZERO;
         dir_v_ff       <= dns_pkg::DIR_ZERO;
         have_origin_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
      end else begin
         dir_h_ff       <= dir_h_in;
         dir_v_ff       <= dir_v_in;
         have_origin_ff <= have_origin_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      origin_x_ff     <= origin_x_in;
      origin_y_ff     <= origin_y_in;
      origin_index_ff <= origin_index_in;
      if (take) begin
         s1_is_start_ff   <= head.is_start;
         s1_empty_list_ff <= head.empty_list;
         s1_last_ff       <= head.last;
         s1_keep_ff       <= keep;
         s1_primary_ff    <= (dir_h_ff != dns_pkg::DIR_ZERO) ? mag_x : mag_y;
         s1_cross_ff      <= (dir_h_ff != dns_pkg::DIR_ZERO) ? mag_y : mag_x;
         s1_index_ff      <= head.index;
      end
   end

   // Select stage: score vs the running best; answer on last item or empty list.
   assign fire   = en && s1_valid_ff;
   assign score  = {3'b000, s1_primary_ff} + {1'b0, s1_cross_ff, 2'b00};
   assign better = s1_keep_ff && (score < lowest_ff);
   assign next_valid = winner_valid_ff || better;
   assign next_index = better ? s1_index_ff : winner_index_ff;

   always_comb begin
      lowest_in       = lowest_ff;
      winner_index_in = winner_index_ff;
      winner_valid_in = winner_valid_ff;
      rsp_valid_in    = en ? 1'b0 : rsp_valid_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_index_in    = rsp_index_ff;
      if (fire) begin
         if (s1_is_start_ff) begin
            lowest_in       = dns_pkg::SCORE_ALL_ONES;
            winner_index_in = '0;
            winner_valid_in = 1'b0;
            if (s1_empty_list_ff) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               rsp_index_in = '0;
            end
         end else if (s1_last_ff) begin
            rsp_valid_in    = 1'b1;
            rsp_found_in    = next_valid;
            rsp_index_in    = next_valid ? next_index : '0;
            lowest_in       = dns_pkg::SCORE_ALL_ONES;
            winner_index_in = '0;
            winner_valid_in = 1'b0;
         end else if (better) begin
            lowest_in       = score;
            winner_index_in = s1_index_ff;
            winner_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff       <= dns_pkg::SCORE_ALL_ONES;
         winner_index_ff <= '0;
         winner_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         lowest_ff       <= lowest_in;
         winner_index_ff <= winner_index_in;
         winner_valid_ff <= winner_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_best_index = rsp_index_ff;

   a_best_consistent: assert property (@(posedge clock) disable iff (reset)
      winner_valid_ff == (lowest_ff != dns_pkg::SCORE_ALL_ONES))
      else $error("running best score and winner flag disagree");

   a_not_found_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_index_ff == '0)
      else $error("nonzero index on a not found answer");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("answer issued without an item in the select stage");

endmodule

@@ hdl/directional_nearest_select_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directional_nearest_select_top
// Picks the nearest rectangle in a requested direction from a streamed list.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle, start or candidate, and keeps
// that rate as long as answers are taken. An accepted item enters a
// four-entry queue, passes a filter stage that measures its offset from the
// origin, and then a select stage that compares its score with the running
// best; that compare loop sets the rate of one item per cycle. An answer
// is registered on the result port once the item that causes it has passed
// the queue, the filter stage and the select stage. A stalled answer holds
// the back part, and the queue keeps taking items until it is full.
module directional_nearest_select_top #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [1:0]  req_dir_x,
   input  logic [1:0]  req_dir_y,
   input  logic        req_has_current,
   input  logic        req_empty_list,
   input  logic [15:0] req_rect_x,
   input  logic [15:0] req_rect_y,
   input  logic [15:0] req_rect_w,
   input  logic [15:0] req_rect_h,
   input  logic [7:0]  req_entry_index,
   input  logic        req_focusable,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [7:0]  rsp_best_index
);

   dns_pkg::queue_status_type q_status;
   dns_pkg::entry_type        q_entry;
   dns_pkg::entry_type        q_head;
   logic                      q_push;
   logic                      q_pop;

   dns_front #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_dir_x       (req_dir_x),
      .req_dir_y       (req_dir_y),
      .req_has_current (req_has_current),
      .req_empty_list  (req_empty_list),
      .req_rect_x      (req_rect_x),
      .req_rect_y      (req_rect_y),
      .req_rect_w      (req_rect_w),
      .req_rect_h      (req_rect_h),
      .req_entry_index (req_entry_index),
      .req_focusable   (req_focusable),
      .req_last        (req_last),
      .q_status        (q_status),
      .push            (q_push),
      .entry           (q_entry)
   );

   dns_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .entry  (q_entry),
      .pop    (q_pop),
      .head   (q_head),
      .status (q_status)
   );

   dns_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .head           (q_head),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_best_index (rsp_best_index)
   );

endmodule
